/* sv/bba_pkg.sv */
`default_nettype none

package bba_pkg;

  // Bitmap geometry
  localparam int BITMAP_BITS = 4096;
  localparam int WORD_BITS   = 64;
  localparam int MAP_WORDS   = (BITMAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int WADDR_W     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BIT_W       = $clog2(WORD_BITS);
  localparam int IDX_W       = WADDR_W + BIT_W;
  localparam int LIM_W       = IDX_W + 1;

  // Field widths
  localparam int BLK_W  = 32;
  localparam int CNT_W  = 13;
  localparam int STAT_W = 2;

  // Configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // Register indexes
  localparam logic REG_FIRST_BLOCK = 1'b0;
  localparam logic REG_BLOCK_COUNT = 1'b1;

  // Request kinds
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NO_SPACE  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE     = 2'd2;
  localparam logic [STAT_W-1:0] STAT_NOT_ALLOC = 2'd3;

  // Reset values of the registers
  localparam logic [BLK_W-1:0] FIRST_BLOCK_RST = 32'd2;
  localparam logic [CNT_W-1:0] BLOCK_COUNT_RST = 13'd4096;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALLOC_SCAN,
    ST_FREE_RD,
    ST_FREE_WR,
    ST_RESP
  } state_e;

  // Result of the lowest-clear-bit search in one word
  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] pos;
  } scan_t;

endpackage

`default_nettype wire

/* sv/bba_ffz.sv */
`default_nettype none

// Lowest set bit of a candidate word (candidate = free and in range),
// as a binary search over halves.
module bba_ffz (
  input  wire logic [bba_pkg::WORD_BITS-1:0] cand_i,
  output bba_pkg::scan_t                     scan_o
);
  import bba_pkg::*;

  always_comb begin
    logic [WORD_BITS-1:0] v;
    logic [WORD_BITS-1:0] low_mask;
    logic [BIT_W-1:0]     pos;
    v   = cand_i;
    pos = '0;
    for (int l = BIT_W - 1; l >= 0; l--) begin
      low_mask = ~({WORD_BITS{1'b1}} << (1 << l));
      if ((v & low_mask) == '0) begin
        pos[l] = 1'b1;
        v      = v >> (1 << l);
      end
    end
    scan_o.found = |cand_i;
    scan_o.pos   = pos;
  end

endmodule

`default_nettype wire

/* sv/block_bitmap_allocator.sv */
`default_nettype none

// First-fit block allocator over a bitmap of 4096 bits, held in a 64 x 64-bit
// synchronous RAM with a registered read port. An allocate request walks the
// RAM from word 0 upward, one word per cycle, and takes the lowest clear bit
// below the configured block count. A free request goes through index
// subtract, range check and read, bit test and write back, and result; a
// block outside the data area is answered right after the range check.
// One request is in flight at a time; the next request can be
// taken while the previous result still waits in the output register.
// The bitmap is cleared at reset through one valid flop per RAM word, so no
// clearing pass is needed and requests are taken right after reset.
module block_bitmap_allocator (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // Request stream
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [bba_pkg::BLK_W-1:0]    s_axis_tdata,  // [31:0] block_number
  input  wire logic                         s_axis_tuser,  // [0] action
  // Result stream
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  output logic [bba_pkg::BLK_W-1:0]         m_axis_tdata,  // [31:0] granted_block
  output logic [bba_pkg::STAT_W-1:0]        m_axis_tuser,  // [1:0] status
  // Configuration port
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [bba_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [bba_pkg::PDATA_W-1:0]  pwdata,
  output logic [bba_pkg::PDATA_W-1:0]       prdata,
  output logic                              pready
);
  import bba_pkg::*;

  // Registers
  logic [BLK_W-1:0]     first_q;
  logic [CNT_W-1:0]     count_q;
  state_e               state_q, state_d;
  logic [WADDR_W-1:0]   scan_w_q, scan_w_d;
  logic [LIM_W-1:0]     limit_q, limit_d;
  logic [BLK_W-1:0]     idx_q, idx_d;
  logic [STAT_W-1:0]    res_status_q, res_status_d;
  logic [BLK_W-1:0]     res_grant_q, res_grant_d;
  logic                 out_vld_q, out_vld_d;
  logic [STAT_W-1:0]    out_status_q;
  logic [BLK_W-1:0]     out_grant_q;

  // Bitmap RAM and per-word valid flops
  logic [WORD_BITS-1:0] mem_q [MAP_WORDS];
  logic                 vld_q [MAP_WORDS];
  logic [WORD_BITS-1:0] rd_data_q;
  logic                 rd_vld_q;

  logic                 in_xfer;
  logic                 out_load;
  logic                 cfg_we;
  logic                 mem_we;
  logic [WADDR_W-1:0]   mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic [WADDR_W-1:0]   raddr;
  logic                 res_load;

  logic [WORD_BITS-1:0] word;
  logic [LIM_W-1:0]     scan_base;
  logic [LIM_W-1:0]     scan_rem;
  logic [LIM_W-1:0]     next_base;
  logic [WORD_BITS-1:0] range_mask;
  logic [WORD_BITS-1:0] cand;
  scan_t                scan;
  logic                 last_word;
  logic [LIM_W-1:0]     act_limit;
  logic [BIT_W-1:0]     free_bit;

  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign out_load      = (state_q == ST_RESP) && (!out_vld_q || m_axis_tready);

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_BLOCK_COUNT) ? PDATA_W'(count_q) : first_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= FIRST_BLOCK_RST;
      count_q <= BLOCK_COUNT_RST;
    end else if (cfg_we) begin
      if (paddr[2] == REG_FIRST_BLOCK) begin
        first_q <= pwdata[BLK_W-1:0];
      end else begin
        count_q <= pwdata[CNT_W-1:0];
      end
    end
  end

  // Saturated count of managed blocks
  assign act_limit = (32'(count_q) > 32'(BITMAP_BITS)) ? LIM_W'(BITMAP_BITS)
                                                       : LIM_W'(count_q);

  // Word under test; a word never written reads as all free
  assign word = rd_vld_q ? rd_data_q : '0;

  // Scan of one word: only bits below the limit are candidates
  assign scan_base  = LIM_W'({scan_w_q, {BIT_W{1'b0}}});
  assign scan_rem   = limit_q - scan_base;
  assign next_base  = scan_base + LIM_W'(WORD_BITS);
  assign range_mask = (scan_rem >= LIM_W'(WORD_BITS)) ? {WORD_BITS{1'b1}}
                    : ~({WORD_BITS{1'b1}} << scan_rem[BIT_W-1:0]);
  assign cand       = ~word & range_mask;
  assign last_word  = (next_base >= limit_q);
  assign free_bit   = idx_q[BIT_W-1:0];

  bba_ffz u_ffz (
    .cand_i (cand),
    .scan_o (scan)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (s_axis_tuser == ACT_FREE) begin
            state_d = ST_FREE_RD;
          end else if (act_limit == '0) begin
            state_d = ST_RESP;
          end else begin
            state_d = ST_ALLOC_SCAN;
          end
        end
      end
      ST_ALLOC_SCAN: begin
        if (scan.found || last_word) begin
          state_d = ST_RESP;
        end
      end
      ST_FREE_RD: begin
        if (idx_q >= BLK_W'(limit_q)) begin
          state_d = ST_RESP;
        end else begin
          state_d = ST_FREE_WR;
        end
      end
      ST_FREE_WR: state_d = ST_RESP;
      ST_RESP: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath control and result
  always_comb begin
    scan_w_d     = scan_w_q;
    limit_d      = limit_q;
    idx_d        = idx_q;
    res_load     = 1'b0;
    res_status_d = STAT_OK;
    res_grant_d  = '0;
    mem_we       = 1'b0;
    mem_waddr    = scan_w_q;
    mem_wdata    = word;
    raddr        = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          scan_w_d = '0;
          limit_d  = act_limit;
          idx_d    = s_axis_tdata - first_q;
          if ((s_axis_tuser == ACT_ALLOC) && (act_limit == '0)) begin
            res_load     = 1'b1;
            res_status_d = STAT_NO_SPACE;
          end
        end
      end
      ST_ALLOC_SCAN: begin
        // read of the following word is issued while this one is tested
        raddr = scan_w_q + WADDR_W'(1);
        if (scan.found) begin
          mem_we       = 1'b1;
          mem_waddr    = scan_w_q;
          mem_wdata    = word | (WORD_BITS'(1) << scan.pos);
          res_load     = 1'b1;
          res_status_d = STAT_OK;
          res_grant_d  = first_q + BLK_W'({scan_w_q, scan.pos});
        end else if (last_word) begin
          res_load     = 1'b1;
          res_status_d = STAT_NO_SPACE;
        end else begin
          scan_w_d = scan_w_q + WADDR_W'(1);
        end
      end
      ST_FREE_RD: begin
        raddr = idx_q[IDX_W-1:BIT_W];
        if (idx_q >= BLK_W'(limit_q)) begin
          res_load     = 1'b1;
          res_status_d = STAT_RANGE;
        end
      end
      ST_FREE_WR: begin
        mem_waddr = idx_q[IDX_W-1:BIT_W];
        res_load  = 1'b1;
        if (!word[free_bit]) begin
          res_status_d = STAT_NOT_ALLOC;
        end else begin
          mem_we       = 1'b1;
          mem_wdata    = word & ~(WORD_BITS'(1) << free_bit);
          res_status_d = STAT_OK;
        end
      end
      ST_RESP: begin
      end
      default: begin
      end
    endcase
  end

  // Output register valid
  always_comb begin
    out_vld_d = out_vld_q;
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
      rd_vld_q  <= 1'b0;
      for (int i = 0; i < MAP_WORDS; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
      rd_vld_q  <= vld_q[raddr];
      if (mem_we) begin
        vld_q[mem_waddr] <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    scan_w_q <= scan_w_d;
    limit_q  <= limit_d;
    idx_q    <= idx_d;
    if (res_load) begin
      res_status_q <= res_status_d;
      res_grant_q  <= res_grant_d;
    end
    if (out_load) begin
      out_status_q <= res_status_q;
      out_grant_q  <= res_grant_q;
    end
  end

  // Bitmap RAM: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem_q[raddr];
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_grant_q;
  assign m_axis_tuser  = out_status_q;

`ifndef NO_ASSERTIONS
  // a granted block number only comes with an ok status
  a_grant_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata != '0)) |-> (m_axis_tuser == STAT_OK))
    else $error("nonzero granted block with error status");

  // the bitmap is only written from the scan or the free write-back
  a_we_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> ((state_q == ST_ALLOC_SCAN) || (state_q == ST_FREE_WR)))
    else $error("bitmap write outside a request");

  // the scan never looks at a word wholly above the limit
  a_scan_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ALLOC_SCAN) |-> (scan_base < limit_q))
    else $error("scan past the block count");

  // a transfer starts work and blocks further requests
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !s_axis_tready)
    else $error("request taken while busy");
`endif

endmodule

`default_nettype wire
